@@ hdl/stereo_compressor_limiter_unit_defines.svh @@
// assertion macros shared by the stereo compressor limiter rtl
// expects clk and rst_n to be visible where a macro is used
`ifndef STEREO_COMPRESSOR_LIMITER_UNIT_DEFINES_SVH
`define STEREO_COMPRESSOR_LIMITER_UNIT_DEFINES_SVH

// condition implies consequence in the same cycle
`define SCL_ASSERT_IMP(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error(msg);

// condition implies consequence in the next cycle
`define SCL_ASSERT_NXT(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

@@ hdl/scl_pkg.sv @@
// constants, band tables and register codes of the stereo compressor limiter
// no dependencies
`default_nettype none

package scl_pkg;

    // envelope memory: six band envelopes and the limiter gain
    localparam int ENV_DEPTH = 8;
    localparam int ENV_AW    = 3;
    localparam logic [ENV_AW-1:0] LIM_ENTRY = 3'd6;

    // configuration port
    localparam int CFG_AW = 5;
    localparam logic [2:0] REG_ENABLE   = 3'd0;
    localparam logic [2:0] REG_DISTANCE = 3'd1;
    localparam logic [2:0] REG_MAKEUP   = 3'd2;
    localparam logic [2:0] REG_SLIM_EN  = 3'd3;
    localparam logic [2:0] REG_LIM_THR  = 3'd4;

    // register reset values
    localparam logic        ENABLE_RST   = 1'b1;
    localparam logic [15:0] DISTANCE_RST = 16'd26214;
    localparam logic [15:0] MAKEUP_RST   = 16'd16384;
    localparam logic        SLIM_EN_RST  = 1'b1;
    localparam logic [14:0] LIM_THR_RST  = 15'd29491;

    // fixed-point constants
    localparam logic [13:0] AVG_Q15      = 14'd10813;
    localparam logic [15:0] KNEE_Q15     = 16'd9830;
    localparam logic [9:0]  LIM_ATT_Q16  = 10'd66;
    localparam logic [9:0]  LIM_REL_Q16  = 10'd655;
    localparam logic [15:0] MAKEUP_MIN   = 16'd1638;
    localparam logic [15:0] MAKEUP_MAX   = 16'd32768;
    localparam logic [15:0] UNITY_Q15    = 16'd32768;
    localparam logic [16:0] KNEE_FULL    = 17'h10000;

    // compressor threshold, Q1.15
    function automatic logic [15:0] band_thr(input logic [1:0] b);
        unique case (b)
            2'd1:    return 16'd13107;
            2'd2:    return 16'd9830;
            default: return 16'd16384;
        endcase
    endfunction

    // threshold times (ratio - 1)
    function automatic logic [16:0] band_thr_rm1(input logic [1:0] b);
        unique case (b)
            2'd1:    return 17'd39321;
            2'd2:    return 17'd49150;
            default: return 17'd32768;
        endcase
    endfunction

    function automatic logic [2:0] band_ratio(input logic [1:0] b);
        unique case (b)
            2'd1:    return 3'd4;
            2'd2:    return 3'd6;
            default: return 3'd3;
        endcase
    endfunction

    // attack coefficient, Q0.16
    function automatic logic [12:0] band_att(input logic [1:0] b);
        unique case (b)
            2'd1:    return 13'd328;
            2'd2:    return 13'd131;
            default: return 13'd655;
        endcase
    endfunction

    // release coefficient, Q0.16
    function automatic logic [12:0] band_rel(input logic [1:0] b);
        unique case (b)
            2'd1:    return 13'd3277;
            2'd2:    return 13'd1311;
            default: return 13'd6554;
        endcase
    endfunction

    // band output gain, Q1.14
    function automatic logic [14:0] band_gain(input logic [1:0] b);
        unique case (b)
            2'd1:    return 15'd18022;
            2'd2:    return 15'd14746;
            default: return 15'd16384;
        endcase
    endfunction

endpackage

`default_nettype wire

@@ hdl/scl_ifs.sv @@
// valid/ready stream interfaces for stereo frames and processed results
// no dependencies
`default_nettype none

interface scl_frame_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] left_in;
    logic signed [15:0] right_in;
    logic               end_of_block;

    modport source (output valid, output left_in, output right_in, output end_of_block,
                    input ready);
    modport sink   (input valid, input left_in, input right_in, input end_of_block,
                    output ready);
endinterface

interface scl_result_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;
    logic               block_end;

    modport source (output valid, output left_out, output right_out, output block_end,
                    input ready);
    modport sink   (input valid, input left_out, input right_out, input block_end,
                    output ready);
endinterface

`default_nettype wire

@@ hdl/scl_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module scl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ hdl/stereo_compressor_limiter_unit.sv @@
// stereo compressor limiter top level: sequencer, shared divider, apb registers
// depends on scl_pkg, scl_ifs, scl_ram and the assertion macro header
`default_nettype none

// One stereo frame is taken per request and gives one result. With enable set,
// each of the six band envelopes is read, stepped and written back through the
// one envelope memory, and when the band compresses its gain needs the shared
// 4-bit-per-cycle divider; then come scaling and knee per channel, the limiter
// (which also uses the divider when it scales; its gain sits in the same
// memory), makeup gain and delivery, and the output register. With enable
// clear a frame skips straight to delivery.
// A new frame is accepted once the previous one has reached the output
// register, which may still wait for the sink. No clearing pass after reset.
`include "stereo_compressor_limiter_unit_defines.svh"

module stereo_compressor_limiter_unit
    import scl_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    scl_frame_if.sink              frame,
    scl_result_if.source           processed,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [CFG_AW-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready
);

    typedef enum logic [18:0] {
        S_IDLE   = 19'd1,
        S_RD     = 19'd2,
        S_ENV    = 19'd4,
        S_DSET   = 19'd8,
        S_DIV    = 19'd16,
        S_GACC   = 19'd32,
        S_MAG    = 19'd64,
        S_PLO    = 19'd128,
        S_PHI    = 19'd256,
        S_CSUM   = 19'd512,
        S_KNEE   = 19'd1024,
        S_LRD    = 19'd2048,
        S_LSET   = 19'd4096,
        S_LENV   = 19'd8192,
        S_LMUL_L = 19'd16384,
        S_LMUL_R = 19'd32768,
        S_MK_L   = 19'd65536,
        S_MK_R   = 19'd131072,
        S_FIN    = 19'd262144
    } state_t;

    // configuration registers
    logic        enable_reg;
    logic [15:0] distance_reg;
    logic [15:0] makeup_reg;
    logic        slim_en_reg;
    logic [14:0] lim_thr_reg;

    // control registers
    state_t          state_reg, state_next;
    logic            ch_reg, ch_next;
    logic [1:0]      band_reg, band_next;
    logic            lim_phase_reg, lim_phase_next;
    logic [1:0]      div_cnt_reg, div_cnt_next;
    logic [ENV_DEPTH-1:0] valid_reg, valid_next;
    logic            ovalid_reg, ovalid_next;

    // payload registers
    logic signed [15:0] xl_reg, xl_next;
    logic signed [15:0] xr_reg, xr_next;
    logic               eob_reg, eob_next;
    logic [15:0]        env_reg, env_next;
    logic [30:0]        gsum_reg, gsum_next;
    logic [46:0]        m_reg, m_next;
    logic [37:0]        plo_reg, plo_next;
    logic [36:0]        phi_reg, phi_next;
    logic [15:0]        cmag_reg, cmag_next;
    logic [15:0]        kmag0_reg, kmag0_next;
    logic [15:0]        kmag1_reg, kmag1_next;
    logic               sgn0_reg, sgn0_next;
    logic               sgn1_reg, sgn1_next;
    logic [15:0]        lg_reg, lg_next;
    logic [17:0]        div_rem_reg, div_rem_next;
    logic [15:0]        div_lo_reg, div_lo_next;
    logic [15:0]        div_q_reg, div_q_next;
    logic [17:0]        div_den_reg, div_den_next;
    logic signed [15:0] res_l_reg, res_l_next;
    logic signed [15:0] res_r_reg, res_r_next;
    logic signed [15:0] oleft_reg, oleft_next;
    logic signed [15:0] oright_reg, oright_next;
    logic               oend_reg, oend_next;

    // envelope memory port
    logic              ram_we;
    logic [ENV_AW-1:0] ram_waddr;
    logic [15:0]       ram_wdata;
    logic              ram_re;
    logic [ENV_AW-1:0] ram_raddr;
    logic [15:0]       ram_rdata;

    // datapath intermediates
    logic signed [15:0] x_cur;
    logic [15:0]        lvl;
    logic [ENV_AW-1:0]  env_addr;
    logic [15:0]        env_rd;
    logic               env_up;
    logic [15:0]        env_d;
    logic [12:0]        env_coef;
    logic [28:0]        env_prod;
    logic [28:0]        env_sum;
    logic [15:0]        env_new;
    logic [17:0]        cmp_den;
    logic [16:0]        cmp_num;
    logic [31:0]        cmp_dvd;
    logic [30:0]        gprod;
    logic [60:0]        csum;
    logic [15:0]        amount;
    logic [16:0]        knee_f;
    logic [15:0]        knee_d;
    logic [32:0]        knee_prod;
    logic [32:0]        knee_sum;
    logic [15:0]        knee_out;
    logic [15:0]        peak;
    logic               lim_act;
    logic [31:0]        lim_dvd;
    logic [15:0]        lg_rd;
    logic               lg_down;
    logic [15:0]        lg_d;
    logic [9:0]         lg_coef;
    logic [25:0]        lg_prod;
    logic [25:0]        lg_sum;
    logic [15:0]        lg_new;
    logic [15:0]        lmul_in;
    logic [31:0]        lmul_sum;
    logic [15:0]        mg;
    logic [31:0]        mk_l_prod;
    logic [31:0]        mk_r_prod;
    logic [31:0]        mk_l_sum;
    logic [31:0]        mk_r_sum;
    logic [17:0]        dv_rem;
    logic [15:0]        dv_lo;
    logic [15:0]        dv_q;
    logic [18:0]        dv_t;
    logic               out_free;
    logic               cfg_wr;

    // saturate a sign and magnitude to a 16-bit sample
    function automatic logic signed [15:0] sat_out(input logic neg, input logic [17:0] m);
        logic signed [15:0] r;
        if (!neg)
        begin
            r = (m > 18'd32767) ? 16'sh7fff : $signed(m[15:0]);
        end
        else
        begin
            r = (m > 18'd32768) ? 16'sh8000 : $signed(16'(~m[15:0] + 16'd1));
        end
        return r;
    endfunction

    scl_ram #(
        .WIDTH (16),
        .DEPTH (ENV_DEPTH)
    ) u_env_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // handshake outputs
    assign frame.ready         = (state_reg == S_IDLE);
    assign processed.valid     = ovalid_reg;
    assign processed.left_out  = oleft_reg;
    assign processed.right_out = oright_reg;
    assign processed.block_end = oend_reg;
    assign out_free            = !ovalid_reg || processed.ready;

    // apb port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        unique case (paddr[4:2])
            REG_ENABLE:   prdata = {31'd0, enable_reg};
            REG_DISTANCE: prdata = {16'd0, distance_reg};
            REG_MAKEUP:   prdata = {16'd0, makeup_reg};
            REG_SLIM_EN:  prdata = {31'd0, slim_en_reg};
            REG_LIM_THR:  prdata = {17'd0, lim_thr_reg};
            default:      prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg   <= ENABLE_RST;
            distance_reg <= DISTANCE_RST;
            makeup_reg   <= MAKEUP_RST;
            slim_en_reg  <= SLIM_EN_RST;
            lim_thr_reg  <= LIM_THR_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:2])
                REG_ENABLE:   enable_reg   <= pwdata[0];
                REG_DISTANCE: distance_reg <= pwdata[15:0];
                REG_MAKEUP:   makeup_reg   <= pwdata[15:0];
                REG_SLIM_EN:  slim_en_reg  <= pwdata[0];
                REG_LIM_THR:  lim_thr_reg  <= pwdata[14:0];
                default:      ;
            endcase
        end
    end

    // per-band envelope step and gain divider setup
    always_comb
    begin
        x_cur    = ch_reg ? xr_reg : xl_reg;
        lvl      = x_cur[15] ? 16'(~x_cur + 16'sd1) : x_cur;
        env_addr = ch_reg ? (3'd3 + {1'b0, band_reg}) : {1'b0, band_reg};
        env_rd   = valid_reg[env_addr] ? ram_rdata : 16'd0;
        env_up   = lvl > env_rd;
        env_d    = env_up ? (lvl - env_rd) : (env_rd - lvl);
        env_coef = env_up ? band_att(band_reg) : band_rel(band_reg);
        env_prod = 29'(env_d) * 29'(env_coef);
        env_sum  = env_prod + 29'd65535;
        env_new  = env_up ? (env_rd + {3'd0, env_sum[28:16]})
                          : (env_rd - {3'd0, env_sum[28:16]});

        cmp_den = 18'(band_ratio(band_reg)) * 18'(env_reg);
        cmp_num = band_thr_rm1(band_reg) + {1'b0, env_reg};
        cmp_dvd = {cmp_num, 15'd0} + 32'(cmp_den[17:1]);
        gprod   = 31'(div_q_reg) * 31'(band_gain(band_reg));
    end

    // averaging, knee, limiter and makeup arithmetic
    always_comb
    begin
        csum = {phi_reg, 24'd0} + 61'(plo_reg) + (61'd1 << 43);

        amount    = (distance_reg > UNITY_Q15) ? UNITY_Q15 : distance_reg;
        knee_f    = KNEE_FULL - {1'b0, amount};
        knee_d    = cmag_reg - KNEE_Q15;
        knee_prod = 33'(knee_d) * 33'(knee_f);
        knee_sum  = knee_prod + 33'd32768;
        knee_out  = (cmag_reg > KNEE_Q15) ? (KNEE_Q15 + knee_sum[31:16]) : cmag_reg;

        peak    = (kmag0_reg > kmag1_reg) ? kmag0_reg : kmag1_reg;
        lim_act = slim_en_reg && (peak > {1'b0, lim_thr_reg});
        lim_dvd = {2'd0, lim_thr_reg, 15'd0} + 32'(peak[15:1]);
        lg_rd   = valid_reg[LIM_ENTRY] ? ram_rdata : UNITY_Q15;

        lg_down = div_q_reg < lg_reg;
        lg_d    = lg_down ? (lg_reg - div_q_reg) : (div_q_reg - lg_reg);
        lg_coef = lg_down ? LIM_ATT_Q16 : LIM_REL_Q16;
        lg_prod = 26'(lg_d) * 26'(lg_coef);
        lg_sum  = lg_prod + 26'd65535;
        lg_new  = lg_down ? (lg_reg - {6'd0, lg_sum[25:16]})
                          : (lg_reg + {6'd0, lg_sum[25:16]});

        lmul_in  = (state_reg == S_LMUL_R) ? kmag1_reg : kmag0_reg;
        lmul_sum = 32'(lmul_in) * 32'(lg_reg) + 32'd16384;

        if (makeup_reg < MAKEUP_MIN)
        begin
            mg = MAKEUP_MIN;
        end
        else if (makeup_reg > MAKEUP_MAX)
        begin
            mg = MAKEUP_MAX;
        end
        else
        begin
            mg = makeup_reg;
        end
        mk_l_prod = 32'(kmag0_reg) * 32'(mg);
        mk_r_prod = 32'(kmag1_reg) * 32'(mg);
        mk_l_sum  = mk_l_prod + 32'd8192;
        mk_r_sum  = mk_r_prod + 32'd8192;
    end

    // restoring divider, four quotient bits per cycle
    always_comb
    begin
        dv_rem = div_rem_reg;
        dv_lo  = div_lo_reg;
        dv_q   = div_q_reg;
        dv_t   = 19'd0;
        for (int k = 0; k < 4; k++)
        begin
            dv_t  = {dv_rem, dv_lo[15]};
            dv_lo = {dv_lo[14:0], 1'b0};
            if (dv_t >= {1'b0, div_den_reg})
            begin
                dv_t = dv_t - {1'b0, div_den_reg};
                dv_q = {dv_q[14:0], 1'b1};
            end
            else
            begin
                dv_q = {dv_q[14:0], 1'b0};
            end
            dv_rem = dv_t[17:0];
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        ch_next        = ch_reg;
        band_next      = band_reg;
        lim_phase_next = lim_phase_reg;
        div_cnt_next   = div_cnt_reg;
        valid_next     = valid_reg;
        ovalid_next    = ovalid_reg && !processed.ready;
        xl_next        = xl_reg;
        xr_next        = xr_reg;
        eob_next       = eob_reg;
        env_next       = env_reg;
        gsum_next      = gsum_reg;
        m_next         = m_reg;
        plo_next       = plo_reg;
        phi_next       = phi_reg;
        cmag_next      = cmag_reg;
        kmag0_next     = kmag0_reg;
        kmag1_next     = kmag1_reg;
        sgn0_next      = sgn0_reg;
        sgn1_next      = sgn1_reg;
        lg_next        = lg_reg;
        div_rem_next   = div_rem_reg;
        div_lo_next    = div_lo_reg;
        div_q_next     = div_q_reg;
        div_den_next   = div_den_reg;
        res_l_next     = res_l_reg;
        res_r_next     = res_r_reg;
        oleft_next     = oleft_reg;
        oright_next    = oright_reg;
        oend_next      = oend_reg;
        ram_we         = 1'b0;
        ram_waddr      = env_addr;
        ram_wdata      = env_new;
        ram_re         = 1'b0;
        ram_raddr      = env_addr;

        unique case (state_reg)
            S_IDLE:
            begin
                if (frame.valid)
                begin
                    xl_next        = frame.left_in;
                    xr_next        = frame.right_in;
                    eob_next       = frame.end_of_block;
                    ch_next        = 1'b0;
                    band_next      = 2'd0;
                    lim_phase_next = 1'b0;
                    if (enable_reg)
                    begin
                        state_next = S_RD;
                    end
                    else
                    begin
                        res_l_next = frame.left_in;
                        res_r_next = frame.right_in;
                        state_next = S_FIN;
                    end
                end
            end
            // fetch this band's envelope
            S_RD:
            begin
                ram_re     = 1'b1;
                state_next = S_ENV;
            end
            // step the envelope and write it back
            S_ENV:
            begin
                ram_we               = 1'b1;
                valid_next[env_addr] = 1'b1;
                env_next             = env_new;
                state_next           = S_DSET;
            end
            // above threshold the gain needs a division, else unity
            S_DSET:
            begin
                if (env_reg > band_thr(band_reg))
                begin
                    div_rem_next = {2'd0, cmp_dvd[31:16]};
                    div_lo_next  = cmp_dvd[15:0];
                    div_den_next = cmp_den;
                    div_q_next   = 16'd0;
                    div_cnt_next = 2'd0;
                    state_next   = S_DIV;
                end
                else
                begin
                    div_q_next = UNITY_Q15;
                    state_next = S_GACC;
                end
            end
            S_DIV:
            begin
                div_rem_next = dv_rem;
                div_lo_next  = dv_lo;
                div_q_next   = dv_q;
                div_cnt_next = div_cnt_reg + 2'd1;
                if (div_cnt_reg == 2'd3)
                begin
                    state_next = lim_phase_reg ? S_LENV : S_GACC;
                end
            end
            // accumulate gain times band gain over the three bands
            S_GACC:
            begin
                gsum_next = ((band_reg == 2'd0) ? 31'd0 : gsum_reg) + gprod;
                if (band_reg == 2'd2)
                begin
                    state_next = S_MAG;
                end
                else
                begin
                    band_next  = band_reg + 2'd1;
                    state_next = S_RD;
                end
            end
            S_MAG:
            begin
                m_next     = 47'(lvl) * 47'(gsum_reg);
                state_next = S_PLO;
            end
            // averaging factor in two partial products
            S_PLO:
            begin
                plo_next   = 38'(m_reg[23:0]) * 38'(AVG_Q15);
                state_next = S_PHI;
            end
            S_PHI:
            begin
                phi_next   = 37'(m_reg[46:24]) * 37'(AVG_Q15);
                state_next = S_CSUM;
            end
            S_CSUM:
            begin
                cmag_next  = csum[59:44];
                state_next = S_KNEE;
            end
            S_KNEE:
            begin
                if (ch_reg)
                begin
                    kmag1_next = knee_out;
                    sgn1_next  = x_cur[15];
                    state_next = S_LRD;
                end
                else
                begin
                    kmag0_next = knee_out;
                    sgn0_next  = x_cur[15];
                    ch_next    = 1'b1;
                    band_next  = 2'd0;
                    state_next = S_RD;
                end
            end
            // fetch the limiter gain
            S_LRD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = LIM_ENTRY;
                state_next = S_LSET;
            end
            S_LSET:
            begin
                lg_next = lg_rd;
                if (lim_act)
                begin
                    div_rem_next   = {2'd0, lim_dvd[31:16]};
                    div_lo_next    = lim_dvd[15:0];
                    div_den_next   = {2'd0, peak};
                    div_q_next     = 16'd0;
                    div_cnt_next   = 2'd0;
                    lim_phase_next = 1'b1;
                    state_next     = S_DIV;
                end
                else
                begin
                    state_next = S_MK_L;
                end
            end
            // step the limiter gain toward its target and write it back
            S_LENV:
            begin
                ram_we                = 1'b1;
                ram_waddr             = LIM_ENTRY;
                ram_wdata             = lg_new;
                valid_next[LIM_ENTRY] = 1'b1;
                lg_next               = lg_new;
                state_next            = S_LMUL_L;
            end
            S_LMUL_L:
            begin
                kmag0_next = lmul_sum[30:15];
                state_next = S_LMUL_R;
            end
            S_LMUL_R:
            begin
                kmag1_next = lmul_sum[30:15];
                state_next = S_MK_L;
            end
            // makeup gain and saturation
            S_MK_L:
            begin
                res_l_next = sat_out(sgn0_reg, mk_l_sum[31:14]);
                state_next = S_MK_R;
            end
            S_MK_R:
            begin
                res_r_next     = sat_out(sgn1_reg, mk_r_sum[31:14]);
                lim_phase_next = 1'b0;
                state_next     = S_FIN;
            end
            // hand the frame to the output register
            S_FIN:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    oleft_next  = res_l_reg;
                    oright_next = res_r_reg;
                    oend_next   = eob_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ch_reg        <= 1'b0;
            band_reg      <= 2'd0;
            lim_phase_reg <= 1'b0;
            div_cnt_reg   <= 2'd0;
            valid_reg     <= '0;
            ovalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ch_reg        <= ch_next;
            band_reg      <= band_next;
            lim_phase_reg <= lim_phase_next;
            div_cnt_reg   <= div_cnt_next;
            valid_reg     <= valid_next;
            ovalid_reg    <= ovalid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        xl_reg      <= xl_next;
        xr_reg      <= xr_next;
        eob_reg     <= eob_next;
        env_reg     <= env_next;
        gsum_reg    <= gsum_next;
        m_reg       <= m_next;
        plo_reg     <= plo_next;
        phi_reg     <= phi_next;
        cmag_reg    <= cmag_next;
        kmag0_reg   <= kmag0_next;
        kmag1_reg   <= kmag1_next;
        sgn0_reg    <= sgn0_next;
        sgn1_reg    <= sgn1_next;
        lg_reg      <= lg_next;
        div_rem_reg <= div_rem_next;
        div_lo_reg  <= div_lo_next;
        div_q_reg   <= div_q_next;
        div_den_reg <= div_den_next;
        res_l_reg   <= res_l_next;
        res_r_reg   <= res_r_next;
        oleft_reg   <= oleft_next;
        oright_reg  <= oright_next;
        oend_reg    <= oend_next;
    end

    // checks
    `SCL_ASSERT_NXT(a_accept_starts, frame.valid && frame.ready, state_reg != S_IDLE,
                    "accepted request did not start")
    `SCL_ASSERT_IMP(a_ram_write_state, ram_we, state_reg == S_ENV || state_reg == S_LENV,
                    "envelope write outside a write-back step")
    `SCL_ASSERT_IMP(a_div_den_nonzero, state_reg == S_DIV, div_den_reg != 18'd0,
                    "divider running with zero divisor")
    `SCL_ASSERT_NXT(a_fin_delivers, state_reg == S_FIN && out_free,
                    ovalid_reg && state_reg == S_IDLE, "finished request not delivered")

endmodule

`default_nettype wire
